/* sv/eddr_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the RGB error diffusion dither.
package eddr_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int FRAC_BITS_DEF = 8;
    // Integer headroom of the signed error sums above the fraction bits.
    localparam int ACC_INT_BITS  = 12;
    localparam int NUM_CH        = 3;

    localparam logic [11:0] WIDTH_RST  = 12'd640;
    localparam logic [15:0] HEIGHT_RST = 16'd480;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register select, word address bit of paddr.
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic fire;
        logic use_acc;
        logic last_col;
        logic last_row;
    } t_lane_ctrl;

    typedef struct packed {
        logic rd_en;
        logic left_en;
        logic tail_en;
    } t_lb_ctrl;

endpackage

/* sv/eddr_if.sv */
`timescale 1ns / 1ps
// Pixel stream interfaces for the dither input and result channels.
interface eddr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface eddr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output frame_end, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input frame_end, output ready);
endinterface

/* sv/error_diffusion_dither_rgb_top.sv */
`timescale 1ns / 1ps
// Top level of the RGB Floyd-Steinberg dither: position counters, lanes, output.
// A result passes through the input stage register and then the result register.
// Throughput: one pixel per cycle while the output is not stalled; the right-neighbor
// error loop inside each lane (add, threshold, times-seven share) closes through r_carry.
// Reset (synchronous, active low) clears pipeline valids, error carries and
// counters, sets width 640 and height 480; the line buffer is not cleared.
module error_diffusion_dither_rgb_top #(
    parameter int MAX_WIDTH = eddr_pkg::MAX_WIDTH_DEF,
    parameter int FRAC_BITS = eddr_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    eddr_in_if.sink                     i_pix,
    eddr_out_if.source                  o_pix,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [eddr_pkg::APB_AW-1:0] paddr,
    input  logic [eddr_pkg::APB_DW-1:0] pwdata,
    output logic [eddr_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int ACC_W = FRAC_BITS + eddr_pkg::ACC_INT_BITS;
    localparam int DW    = eddr_pkg::NUM_CH * ACC_W;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int LW    = ((CW > 12) ? CW : 12) + 1;

    logic [11:0]   r_width;
    logic [15:0]   r_height;
    logic [CW-1:0] r_col;
    logic [15:0]   r_row;

    logic          r_s1_v;
    logic [7:0]    r_s1_pix [eddr_pkg::NUM_CH];
    logic [CW-1:0] r_s1_col;
    logic          r_s1_use;
    logic          r_s1_last_col;
    logic          r_s1_last_row;

    logic          r_out_v;
    logic [7:0]    r_out_ch [eddr_pkg::NUM_CH];
    logic          r_out_end;

    logic          accept, s1_fire, wr_cfg;
    logic [LW-1:0] w_ext, w_last;
    logic [CW-1:0] col_last;
    logic [15:0]   row_last;
    logic          last_col, last_row;

    eddr_pkg::t_lane_ctrl lane_ctrl;
    eddr_pkg::t_lb_ctrl   lb_ctrl;
    logic [DW-1:0]        rd_data, left_data, here_data;
    logic [eddr_pkg::NUM_CH-1:0] q;

    // Configuration port
    assign pready = 1'b1;
    assign wr_cfg = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= eddr_pkg::WIDTH_RST;
            r_height <= eddr_pkg::HEIGHT_RST;
        end else if (wr_cfg) begin
            unique case (paddr[2])
                eddr_pkg::REG_IMAGE_WIDTH:  r_width  <= pwdata[11:0];
                eddr_pkg::REG_IMAGE_HEIGHT: r_height <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            eddr_pkg::REG_IMAGE_WIDTH:  prdata = {20'b0, r_width};
            eddr_pkg::REG_IMAGE_HEIGHT: prdata = {16'b0, r_height};
            default:                    prdata = '0;
        endcase
    end

    // Position of the incoming pixel
    assign w_ext    = LW'(r_width);
    assign w_last   = (w_ext == '0) ? '0 :
                      ((w_ext > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH - 1) : (w_ext - 1'b1));
    assign col_last = w_last[CW-1:0];
    assign row_last = (r_height == '0) ? '0 : (r_height - 1'b1);
    assign last_col = (r_col >= col_last);
    assign last_row = (r_row >= row_last);

    assign s1_fire     = r_s1_v && (!r_out_v || o_pix.ready);
    assign i_pix.ready = !r_s1_v || s1_fire;
    assign accept      = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : (r_row + 1'b1);
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end else if (s1_fire) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix[0]   <= i_pix.red_in;
            r_s1_pix[1]   <= i_pix.green_in;
            r_s1_pix[2]   <= i_pix.blue_in;
            r_s1_col      <= r_col;
            r_s1_use      <= (r_row != '0);
            r_s1_last_col <= last_col;
            r_s1_last_row <= last_row;
        end
    end

    // Line buffer
    assign lb_ctrl.rd_en   = accept;
    assign lb_ctrl.left_en = s1_fire && !r_s1_last_row && (r_s1_col != '0);
    assign lb_ctrl.tail_en = s1_fire && !r_s1_last_row && r_s1_last_col;

    eddr_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (DW)
    ) u_linebuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (lb_ctrl),
        .i_rd_addr   (r_col),
        .i_left_addr (r_s1_col - 1'b1),
        .i_left_data (left_data),
        .i_tail_addr (r_s1_col),
        .i_tail_data (here_data),
        .o_rd_data   (rd_data)
    );

    // Channel lanes
    assign lane_ctrl.fire     = s1_fire;
    assign lane_ctrl.use_acc  = r_s1_use;
    assign lane_ctrl.last_col = r_s1_last_col;
    assign lane_ctrl.last_row = r_s1_last_row;

    for (genvar c = 0; c < eddr_pkg::NUM_CH; c++) begin : g_lane
        eddr_lane #(
            .FRAC_BITS (FRAC_BITS),
            .ACC_W     (ACC_W)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (lane_ctrl),
            .i_pix   (r_s1_pix[c]),
            .i_acc   (rd_data[c*ACC_W +: ACC_W]),
            .o_q     (q[c]),
            .o_left  (left_data[c*ACC_W +: ACC_W]),
            .o_here  (here_data[c*ACC_W +: ACC_W])
        );
    end

    // Merge into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_fire) begin
            r_out_v <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            for (int c = 0; c < eddr_pkg::NUM_CH; c++) begin
                r_out_ch[c] <= {8{q[c]}};
            end
            r_out_end <= r_s1_last_col && r_s1_last_row;
        end
    end

    assign o_pix.valid     = r_out_v;
    assign o_pix.red_out   = r_out_ch[0];
    assign o_pix.green_out = r_out_ch[1];
    assign o_pix.blue_out  = r_out_ch[2];
    assign o_pix.frame_end = r_out_end;

endmodule

/* sv/eddr_lane.sv */
`timescale 1ns / 1ps
// One color channel: threshold, error split and the per-row error carries.
module eddr_lane #(
    parameter int FRAC_BITS = eddr_pkg::FRAC_BITS_DEF,
    parameter int ACC_W     = eddr_pkg::FRAC_BITS_DEF + eddr_pkg::ACC_INT_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  eddr_pkg::t_lane_ctrl    i_ctrl,
    input  logic [7:0]              i_pix,
    input  logic signed [ACC_W-1:0] i_acc,
    output logic                    o_q,
    output logic signed [ACC_W-1:0] o_left,
    output logic signed [ACC_W-1:0] o_here
);

    localparam int PW = ACC_W + 3;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(255 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] FULL = ACC_W'(255 << FRAC_BITS);

    logic signed [ACC_W-1:0] r_carry, r_pb, r_pbl;
    logic signed [ACC_W-1:0] pix_fx, acc_sel, v, e;
    logic signed [PW-1:0]    e_x, p7, p5, p3;
    logic signed [ACC_W-1:0] s7, s5, s3, s1;

    assign pix_fx  = {{(ACC_W - 8 - FRAC_BITS){1'b0}}, i_pix, {FRAC_BITS{1'b0}}};
    assign acc_sel = i_ctrl.use_acc ? i_acc : '0;
    assign v       = pix_fx + r_carry + acc_sel;
    assign o_q     = (v >= HALF);
    assign e       = o_q ? (v - FULL) : v;

    assign e_x = {{3{e[ACC_W-1]}}, e};
    assign p7  = (e_x <<< 3) - e_x;
    assign p5  = (e_x <<< 2) + e_x;
    assign p3  = (e_x <<< 1) + e_x;
    // Arithmetic shift gives the floored sixteenth.
    assign s7  = ACC_W'(p7 >>> 4);
    assign s5  = ACC_W'(p5 >>> 4);
    assign s3  = ACC_W'(p3 >>> 4);
    assign s1  = e >>> 4;

    assign o_left = r_pbl + s3;
    assign o_here = r_pb + s5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
            r_pb    <= '0;
            r_pbl   <= '0;
        end else if (i_ctrl.fire) begin
            r_carry <= i_ctrl.last_col ? '0 : s7;
            if (i_ctrl.last_row || i_ctrl.last_col) begin
                r_pbl <= '0;
                r_pb  <= '0;
            end else begin
                r_pbl <= o_here;
                r_pb  <= s1;
            end
        end
    end

endmodule

/* sv/eddr_linebuf.sv */
`timescale 1ns / 1ps
// Next-row error line buffer with one write port, registered read and bypass.
module eddr_linebuf #(
    parameter int DEPTH = eddr_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(eddr_pkg::MAX_WIDTH_DEF),
    parameter int DW    = 3 * (eddr_pkg::FRAC_BITS_DEF + eddr_pkg::ACC_INT_BITS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  eddr_pkg::t_lb_ctrl i_ctrl,
    input  logic [AW-1:0]      i_rd_addr,
    input  logic [AW-1:0]      i_left_addr,
    input  logic [DW-1:0]      i_left_data,
    input  logic [AW-1:0]      i_tail_addr,
    input  logic [DW-1:0]      i_tail_data,
    output logic [DW-1:0]      o_rd_data
);

    logic [DW-1:0] mem [DEPTH];

    logic          r_tail_v;
    logic [AW-1:0] r_tail_addr;
    logic [DW-1:0] r_tail_data;
    logic [DW-1:0] r_mem_q;
    logic          r_byp_en;
    logic [DW-1:0] r_byp_data;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic          n_byp_en;
    logic [DW-1:0] n_byp_data;

    // End-of-row entry is parked and written in the next free write slot.
    assign wr_en   = i_ctrl.left_en || r_tail_v;
    assign wr_addr = i_ctrl.left_en ? i_left_addr : r_tail_addr;
    assign wr_data = i_ctrl.left_en ? i_left_data : r_tail_data;

    always_comb begin
        n_byp_en   = 1'b1;
        n_byp_data = '0;
        if (i_ctrl.tail_en && (i_tail_addr == i_rd_addr)) begin
            n_byp_data = i_tail_data;
        end else if (wr_en && (wr_addr == i_rd_addr)) begin
            n_byp_data = wr_data;
        end else if (r_tail_v && (r_tail_addr == i_rd_addr)) begin
            n_byp_data = r_tail_data;
        end else begin
            n_byp_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_mem_q    <= mem[i_rd_addr];
            r_byp_en   <= n_byp_en;
            r_byp_data <= n_byp_data;
        end
        if (i_ctrl.tail_en) begin
            r_tail_addr <= i_tail_addr;
            r_tail_data <= i_tail_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_v <= 1'b0;
        end else if (i_ctrl.tail_en) begin
            r_tail_v <= 1'b1;
        end else if (!i_ctrl.left_en) begin
            r_tail_v <= 1'b0;
        end
    end

    assign o_rd_data = r_byp_en ? r_byp_data : r_mem_q;

endmodule

/* sv/eddr_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the dither top level, bound to every instance.
module eddr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_red,
    input logic [7:0] i_green,
    input logic [7:0] i_blue,
    input logic       i_frame_end
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_red) &&
        $stable(i_green) && $stable(i_blue) && $stable(i_frame_end))
        else $error("result changed while stalled");

    a_two_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_red == 8'd0 || i_red == 8'd255) &&
        (i_green == 8'd0 || i_green == 8'd255) &&
        (i_blue == 8'd0 || i_blue == 8'd255))
        else $error("dithered channel not 0 or 255");

    a_stall_only_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without output backpressure");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid, 2) || $past(i_in_valid))
        else $error("result without earlier input");

endmodule

bind error_diffusion_dither_rgb_top eddr_checker u_eddr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_red       (o_pix.red_out),
    .i_green     (o_pix.green_out),
    .i_blue      (o_pix.blue_out),
    .i_frame_end (o_pix.frame_end)
);
